/* src/mfmd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_pkg
// Types, constants and the CRC step shared by the MFM flux sync decoder.
// ----------------------------------------------------------------------------
package mfmd_pkg;

    localparam int TIME_W  = 16;
    localparam int PRE_W   = 8;
    localparam int LEN_W   = 11;
    localparam int STEP_W  = 4;
    localparam int SHIFT_W = 9;
    localparam int LEFT_W  = 4;
    localparam int CRC_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 16;

    localparam logic [CRC_W-1:0]  CRC_PRESET  = 16'hCDB4;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
    localparam logic [STEP_W-1:0] SYNC_LEN    = 4'd14;
    localparam logic [PRE_W-1:0]  PRE_SAT     = 8'hFF;
    localparam logic [LEN_W-1:0]  MIN_RECORD  = 11'd3;
    localparam logic [16:0]       MAX_RECORD  = 17'd1024;
    localparam logic [LEN_W-1:0]  BCOUNT_SAT  = 11'h7FF;
    localparam logic [LEFT_W-1:0] BITS_FULL   = 4'd8;
    localparam logic [LEFT_W-1:0] BITS_SPILL  = 4'd7;

    localparam logic [TIME_W-1:0] RST_MEDIUM_ABOVE = 16'd80;
    localparam logic [TIME_W-1:0] RST_LONG_ABOVE   = 16'd112;
    localparam logic [PRE_W-1:0]  RST_PREAMBLE_MIN = 8'd80;
    localparam logic [LEN_W-1:0]  RST_RECORD_BYTES = 11'd515;

    typedef enum logic [IDX_W-1:0] {
        REG_MEDIUM_ABOVE = 2'd0,
        REG_LONG_ABOVE   = 2'd1,
        REG_PREAMBLE_MIN = 2'd2,
        REG_RECORD_BYTES = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PULSE_SHORT  = 2'd1,
        PULSE_MEDIUM = 2'd2,
        PULSE_LONG   = 2'd3
    } pulse_t;

    typedef struct packed {
        logic [PRE_W-1:0] preamble_min;
        logic [LEN_W-1:0] record_bytes;
    } core_cfg_t;

    typedef struct packed {
        logic   valid;
        pulse_t pulse;
    } pulse_item_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* src/mfmd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_if
// Valid/ready channels of the MFM flux sync decoder: flux captures, decoded
// bytes and register writes.
// ----------------------------------------------------------------------------
interface mfmd_in_if;
    logic                        valid;
    logic                        ready;
    logic [mfmd_pkg::TIME_W-1:0] capture_time;

    modport source (output valid, output capture_time, input ready);
    modport sink   (input valid, input capture_time, output ready);
endinterface

interface mfmd_out_if;
    logic                        valid;
    logic                        ready;
    logic [mfmd_pkg::BYTE_W-1:0] data_byte;
    logic                        last_in_record;
    logic                        crc_ok;

    modport source (output valid, output data_byte, output last_in_record,
                    output crc_ok, input ready);
    modport sink   (input valid, input data_byte, input last_in_record,
                    input crc_ok, output ready);
endinterface

interface mfmd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mfmd_pkg::IDX_W-1:0]  index;
    logic [mfmd_pkg::DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/mfm_flux_sync_decoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mfm_flux_sync_decoder_unit
// MFM flux sync decoder: pulse timing, sync hunt, byte decode and CRC check.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  flux     in   capture_time[15:0]
//  result   out  data_byte[7:0], last_in_record, crc_ok
//  cfg      in   index[1:0], data[15:0]
//
//  one capture per cycle unless stalled; a capture is registered on input and
//  yields at most one byte, held in the result register until taken
//  flux is still taken while a byte waits if the result register drains
//  reset returns to hunting with default thresholds; cfg is always ready
// ----------------------------------------------------------------------------
module mfm_flux_sync_decoder_unit #(
    parameter logic [16:0] MAX_RECORD = mfmd_pkg::MAX_RECORD
) (
    input  wire         clk,
    input  wire         rst_n,
    mfmd_in_if.sink     flux,
    mfmd_out_if.source  result,
    mfmd_cfg_if.sink    cfg
);

    logic [mfmd_pkg::TIME_W-1:0] medium_above_reg;
    logic [mfmd_pkg::TIME_W-1:0] long_above_reg;
    logic [mfmd_pkg::PRE_W-1:0]  preamble_min_reg;
    logic [mfmd_pkg::LEN_W-1:0]  record_bytes_reg;

    logic                        in_valid_reg;
    logic [mfmd_pkg::TIME_W-1:0] in_time_reg;
    logic [mfmd_pkg::TIME_W-1:0] prev_reg;

    logic                        advance;
    logic                        consume;
    logic [mfmd_pkg::TIME_W-1:0] ticks;
    mfmd_pkg::pulse_item_t       item;
    mfmd_pkg::core_cfg_t         ccfg;

    assign cfg.ready  = 1'b1;
    assign flux.ready = !in_valid_reg || advance;
    assign consume    = in_valid_reg && advance;

    assign ticks = in_time_reg - prev_reg;

    always_comb
    begin
        item.valid = consume;
        priority if (ticks > long_above_reg)
            item.pulse = mfmd_pkg::PULSE_LONG;
        else if (ticks > medium_above_reg)
            item.pulse = mfmd_pkg::PULSE_MEDIUM;
        else
            item.pulse = mfmd_pkg::PULSE_SHORT;
    end

    assign ccfg.preamble_min = preamble_min_reg;
    assign ccfg.record_bytes = record_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            medium_above_reg <= mfmd_pkg::RST_MEDIUM_ABOVE;
            long_above_reg   <= mfmd_pkg::RST_LONG_ABOVE;
            preamble_min_reg <= mfmd_pkg::RST_PREAMBLE_MIN;
            record_bytes_reg <= mfmd_pkg::RST_RECORD_BYTES;
            in_valid_reg     <= 1'b0;
            prev_reg         <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (mfmd_pkg::cfg_index_t'(cfg.index))
                    mfmd_pkg::REG_MEDIUM_ABOVE: medium_above_reg <= cfg.data;
                    mfmd_pkg::REG_LONG_ABOVE:   long_above_reg   <= cfg.data;
                    mfmd_pkg::REG_PREAMBLE_MIN:
                        preamble_min_reg <= cfg.data[mfmd_pkg::PRE_W-1:0];
                    mfmd_pkg::REG_RECORD_BYTES:
                        record_bytes_reg <= cfg.data[mfmd_pkg::LEN_W-1:0];
                endcase
            end
            if (flux.ready)
                in_valid_reg <= flux.valid;
            if (consume)
                prev_reg <= in_time_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flux.ready && flux.valid)
            in_time_reg <= flux.capture_time;
    end

    mfmd_core #(
        .MAX_RECORD (MAX_RECORD)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .ccfg    (ccfg),
        .advance (advance),
        .result  (result)
    );

endmodule
`default_nettype wire

/* src/mfmd_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_core
// Preamble and sync hunt, MFM bit decode, byte framing, CRC check and the
// result register.
// ----------------------------------------------------------------------------
module mfmd_core #(
    parameter logic [16:0] MAX_RECORD = mfmd_pkg::MAX_RECORD
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  mfmd_pkg::pulse_item_t item,
    input  mfmd_pkg::core_cfg_t  ccfg,
    output logic                 advance,
    mfmd_out_if.source           result
);

    logic                          data_mode_reg, data_mode_next;
    logic [mfmd_pkg::PRE_W-1:0]    pre_cnt_reg, pre_cnt_next;
    logic [mfmd_pkg::STEP_W-1:0]   sync_step_reg, sync_step_next;
    logic                          phase_even_reg, phase_even_next;
    logic [mfmd_pkg::SHIFT_W-1:0]  shift_reg, shift_next;
    logic [mfmd_pkg::LEFT_W-1:0]   left_reg, left_next;
    logic [mfmd_pkg::LEN_W-1:0]    bcount_reg, bcount_next;
    logic [mfmd_pkg::CRC_W-1:0]    crc_reg, crc_next;
    logic [mfmd_pkg::CRC_W-1:0]    stored_reg, stored_next;

    logic                          out_valid_reg;
    logic [mfmd_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                          out_last_reg;
    logic                          out_ok_reg;

    logic                          got;
    logic [mfmd_pkg::BYTE_W-1:0]   byte_val;
    logic                          is_last;
    logic                          ok_val;

    logic [mfmd_pkg::PRE_W-1:0]    pre_inc;
    logic [mfmd_pkg::LEFT_W-1:0]   k;
    logic                          v;
    logic [mfmd_pkg::SHIFT_W-1:0]  shifted;
    logic [mfmd_pkg::LEN_W-1:0]    eff_len;
    logic [mfmd_pkg::LEN_W-1:0]    bc_inc;

    function automatic mfmd_pkg::pulse_t sync_class(input logic [mfmd_pkg::STEP_W-1:0] s);
        mfmd_pkg::pulse_t c;
        unique case (s)
            4'd5, 4'd10: c = mfmd_pkg::PULSE_SHORT;
            4'd1, 4'd3, 4'd6, 4'd8, 4'd11, 4'd13: c = mfmd_pkg::PULSE_LONG;
            default: c = mfmd_pkg::PULSE_MEDIUM;
        endcase
        return c;
    endfunction

    assign advance = !out_valid_reg || result.ready;

    assign result.valid          = out_valid_reg;
    assign result.data_byte      = out_byte_reg;
    assign result.last_in_record = out_last_reg;
    assign result.crc_ok         = out_ok_reg;

    // effective record length
    always_comb
    begin
        if (ccfg.record_bytes < mfmd_pkg::MIN_RECORD)
            eff_len = mfmd_pkg::MIN_RECORD;
        else if ({6'b0, ccfg.record_bytes} > MAX_RECORD)
            eff_len = MAX_RECORD[mfmd_pkg::LEN_W-1:0];
        else
            eff_len = ccfg.record_bytes;
    end

    always_comb
    begin
        data_mode_next  = data_mode_reg;
        pre_cnt_next    = pre_cnt_reg;
        sync_step_next  = sync_step_reg;
        phase_even_next = phase_even_reg;
        shift_next      = shift_reg;
        left_next       = left_reg;
        bcount_next     = bcount_reg;
        crc_next        = crc_reg;
        stored_next     = stored_reg;
        got             = 1'b0;
        byte_val        = '0;
        is_last         = 1'b0;
        ok_val          = 1'b0;

        pre_inc = (pre_cnt_reg < mfmd_pkg::PRE_SAT) ? pre_cnt_reg + 8'd1 : pre_cnt_reg;

        // bit count and value pushed for this pulse
        if (item.pulse == mfmd_pkg::PULSE_SHORT)
            k = 4'd1;
        else if (item.pulse == mfmd_pkg::PULSE_MEDIUM)
            k = phase_even_reg ? 4'd1 : 4'd2;
        else
            k = 4'd2;
        if (item.pulse == mfmd_pkg::PULSE_LONG)
            v = 1'b1;
        else if (item.pulse == mfmd_pkg::PULSE_SHORT)
            v = phase_even_reg;
        else
            v = !phase_even_reg;

        if (k == 4'd2)
            shifted = {shift_reg[6:0], 1'b0, v};
        else
            shifted = {shift_reg[7:0], v};

        bc_inc = (bcount_reg == mfmd_pkg::BCOUNT_SAT) ? bcount_reg : bcount_reg + 11'd1;

        if (item.valid)
        begin
            if (!data_mode_reg)
            begin
                if (sync_step_reg == '0)
                begin
                    priority if (item.pulse == mfmd_pkg::PULSE_SHORT)
                        pre_cnt_next = pre_inc;
                    else if (item.pulse == mfmd_pkg::PULSE_MEDIUM &&
                             pre_inc >= ccfg.preamble_min)
                    begin
                        sync_step_next = 4'd1;
                        pre_cnt_next   = '0;
                    end
                    else
                        pre_cnt_next = '0;
                end
                else if (sync_step_reg > mfmd_pkg::SYNC_LEN ||
                         sync_class(sync_step_reg) != item.pulse)
                begin
                    pre_cnt_next   = '0;
                    sync_step_next = '0;
                end
                else if (sync_step_reg == mfmd_pkg::SYNC_LEN)
                begin
                    data_mode_next  = 1'b1;
                    pre_cnt_next    = '0;
                    sync_step_next  = '0;
                    phase_even_next = 1'b1;
                    shift_next      = '0;
                    left_next       = mfmd_pkg::BITS_FULL;
                    bcount_next     = '0;
                    crc_next        = mfmd_pkg::CRC_PRESET;
                    stored_next     = '0;
                end
                else
                    sync_step_next = sync_step_reg + 4'd1;
            end
            else
            begin
                if (item.pulse == mfmd_pkg::PULSE_MEDIUM)
                    phase_even_next = !phase_even_reg;

                priority if (left_reg < k)
                begin
                    got        = 1'b1;
                    byte_val   = shifted[8:1];
                    shift_next = {8'b0, shifted[0]};
                    left_next  = mfmd_pkg::BITS_SPILL;
                end
                else if (left_reg == k)
                begin
                    got        = 1'b1;
                    byte_val   = shifted[7:0];
                    shift_next = '0;
                    left_next  = mfmd_pkg::BITS_FULL;
                end
                else
                begin
                    shift_next = shifted;
                    left_next  = left_reg - k;
                end

                if (got)
                begin
                    bcount_next = bc_inc;
                    if ({1'b0, bc_inc} + 12'd2 <= {1'b0, eff_len})
                        crc_next = mfmd_pkg::crc_byte(crc_reg, byte_val);
                    else
                        stored_next = {stored_reg[7:0], byte_val};
                    if (bc_inc >= eff_len)
                    begin
                        is_last        = 1'b1;
                        ok_val         = (crc_next == stored_next);
                        data_mode_next = 1'b0;
                        pre_cnt_next   = '0;
                        sync_step_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_mode_reg  <= 1'b0;
            pre_cnt_reg    <= '0;
            sync_step_reg  <= '0;
            phase_even_reg <= 1'b1;
            shift_reg      <= '0;
            left_reg       <= mfmd_pkg::BITS_FULL;
            bcount_reg     <= '0;
            crc_reg        <= mfmd_pkg::CRC_PRESET;
            stored_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            data_mode_reg  <= data_mode_next;
            pre_cnt_reg    <= pre_cnt_next;
            sync_step_reg  <= sync_step_next;
            phase_even_reg <= phase_even_next;
            shift_reg      <= shift_next;
            left_reg       <= left_next;
            bcount_reg     <= bcount_next;
            crc_reg        <= crc_next;
            stored_reg     <= stored_next;
            if (advance)
                out_valid_reg <= item.valid && got;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item.valid && got)
        begin
            out_byte_reg <= byte_val;
            out_last_reg <= is_last;
            out_ok_reg   <= ok_val;
        end
    end

endmodule
`default_nettype wire
